### rtl/ahc_pkg.sv
package ahc_pkg;

  localparam int HEADER_LENGTH = 36;
  localparam int IDX_W         = $clog2(HEADER_LENGTH);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // header byte positions
  localparam int START_OFS = 0;
  localparam int REC_OFS   = 4;
  localparam int MAJOR_OFS = 6;
  localparam int MINOR_OFS = 10;
  localparam int SEQ_OFS   = 14;
  localparam int SEQ_LEN   = 6;
  localparam int ID_OFS    = 20;
  localparam int ID_LEN    = 8;
  localparam int RSV_OFS   = 28;
  localparam int END_OFS   = 32;
  localparam int WORD_LEN  = 4;

  localparam int STATUS_W   = 2;
  localparam int SEQ_W      = 8 * SEQ_LEN;
  localparam int ID_W       = 8 * ID_LEN;
  localparam int OUT_W      = STATUS_W + 1 + SEQ_W + ID_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MAGIC = 2'd0,
    REG_END_MAGIC   = 2'd1,
    REG_MAJOR       = 2'd2,
    REG_MINOR       = 2'd3
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID       = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_RSV_NONZERO = 2'd3
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_magic;
    logic [CFG_W-1:0] end_magic;
    logic [CFG_W-1:0] major_expected;
    logic [CFG_W-1:0] minor_expected;
  } cfg_t;

  typedef struct packed {
    logic [31:0]      start_word;
    logic             rec_nz;
    logic [31:0]      major_word;
    logic [31:0]      minor_word;
    logic [SEQ_W-1:0] seq;
    logic [ID_W-1:0]  id;
    logic [31:0]      rsv_word;
    logic [31:0]      end_word;
  } hdr_t;

endpackage

### rtl/ahc_cfg_regs.sv
module ahc_cfg_regs
  import ahc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_MAGIC: cfg.start_magic    <= cfg_data;
        REG_END_MAGIC:   cfg.end_magic      <= cfg_data;
        REG_MAJOR:       cfg.major_expected <= cfg_data;
        REG_MINOR:       cfg.minor_expected <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ahc_capture.sv
module ahc_capture
  import ahc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] data_byte,
  input  logic       first,
  input  logic       snap_take,
  output logic       snap_valid,
  output hdr_t       snap
);

  logic [IDX_W-1:0] byte_index;
  logic             in_header;
  hdr_t             fields;
  hdr_t             fields_next;
  logic [IDX_W-1:0] idx;
  logic             act;
  logic             acc;
  logic             done;

  // drop the byte into whichever word covers its position
  function automatic hdr_t put_byte(hdr_t h, logic [IDX_W-1:0] pos, logic [7:0] b);
    hdr_t             r;
    logic [IDX_W-1:0] rel;
    r = h;
    if (pos < IDX_W'(START_OFS + WORD_LEN)) begin
      rel = pos - IDX_W'(START_OFS);
      r.start_word[rel[1:0]*8 +: 8] = b;
    end
    if (pos == IDX_W'(REC_OFS)) r.rec_nz = (b != 8'd0);
    if (pos >= IDX_W'(MAJOR_OFS) && pos < IDX_W'(MAJOR_OFS + WORD_LEN)) begin
      rel = pos - IDX_W'(MAJOR_OFS);
      r.major_word[rel[1:0]*8 +: 8] = b;
    end
    if (pos >= IDX_W'(MINOR_OFS) && pos < IDX_W'(MINOR_OFS + WORD_LEN)) begin
      rel = pos - IDX_W'(MINOR_OFS);
      r.minor_word[rel[1:0]*8 +: 8] = b;
    end
    if (pos >= IDX_W'(SEQ_OFS) && pos < IDX_W'(SEQ_OFS + SEQ_LEN)) begin
      rel = pos - IDX_W'(SEQ_OFS);
      r.seq[rel[2:0]*8 +: 8] = b;
    end
    if (pos >= IDX_W'(ID_OFS) && pos < IDX_W'(ID_OFS + ID_LEN)) begin
      rel = pos - IDX_W'(ID_OFS);
      r.id[rel[2:0]*8 +: 8] = b;
    end
    if (pos >= IDX_W'(RSV_OFS) && pos < IDX_W'(RSV_OFS + WORD_LEN)) begin
      rel = pos - IDX_W'(RSV_OFS);
      r.rsv_word[rel[1:0]*8 +: 8] = b;
    end
    if (pos >= IDX_W'(END_OFS) && pos < IDX_W'(END_OFS + WORD_LEN)) begin
      rel = pos - IDX_W'(END_OFS);
      r.end_word[rel[1:0]*8 +: 8] = b;
    end
    return r;
  endfunction

  assign s_tready    = !snap_valid || snap_take;
  assign acc         = s_tvalid && s_tready;
  assign act         = first || in_header;
  assign idx         = first ? '0 : byte_index;
  assign done        = act && (idx == IDX_W'(HEADER_LENGTH - 1));
  assign fields_next = put_byte(fields, idx, data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      in_header  <= 1'b0;
    end else if (acc && act) begin
      if (done) begin
        byte_index <= '0;
        in_header  <= 1'b0;
      end else begin
        byte_index <= idx + 1'b1;
        in_header  <= 1'b1;
      end
    end
  end

  // field words and the snapshot handed to the check stage
  always_ff @(posedge clk) begin
    if (acc && act) fields <= fields_next;
    if (acc && done) snap <= fields_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (acc && done) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

endmodule

### rtl/ahc_check.sv
module ahc_check
  import ahc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   snap_valid,
  input  hdr_t                   snap,
  output logic                   snap_take,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  status_t          status;
  logic             rec;
  logic [SEQ_W-1:0] seq;
  logic [ID_W-1:0]  id;
  logic             out_free;

  always_comb begin
    status = ST_VALID;
    rec    = 1'b0;
    seq    = '0;
    id     = '0;
    if (snap.start_word != cfg.start_magic || snap.end_word != cfg.end_magic) begin
      status = ST_BAD_MAGIC;
    end else if (snap.major_word != cfg.major_expected ||
                 snap.minor_word != cfg.minor_expected) begin
      status = ST_BAD_VERSION;
    end else begin
      rec = snap.rec_nz;
      seq = snap.seq;
      id  = snap.id;
      if (snap.rsv_word != '0) status = ST_RSV_NONZERO;
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign snap_take = snap_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      m_tdata <= {(OUT_TDATA_W - OUT_W)'(0), id, seq, rec, status};
    end
  end

endmodule

### rtl/archive_header_checker.sv
// Archive header checker: one header byte per beat, one result per header.
// The result is registered in the snapshot register, then in the output register.
// Throughput: 1 byte per cycle while s_tready is high; one result per HEADER_LENGTH
// bytes. The snapshot and output registers each hold one header.
// Reset (rst, synchronous): byte counter, header flag, valid flags and the
// magic/version registers go to zero; field words are not reset.
module archive_header_checker
  import ahc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic [0:0]             s_tuser,   // [0] first
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [2] recovery_enabled,
                                            // [50:3] sequence_res, [114:51] archive_id
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_t cfg;
  hdr_t snap;
  logic snap_valid;
  logic snap_take;

  ahc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahc_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .data_byte  (s_tdata),
    .first      (s_tuser[0]),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ahc_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

### rtl/ahc_checker.sv
module ahc_checker
  import ahc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_BAD_MAGIC || m_tdata[1:0] == ST_BAD_VERSION)
      |-> m_tdata[OUT_W-1:STATUS_W] == '0)
    else $error("fields not cleared on magic or version failure");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind archive_header_checker ahc_checker u_ahc_checker (.*);

### bench/archive_header_checker_tb.sv
module archive_header_checker_tb
  import ahc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = END_OFS + WORD_LEN;
  localparam int QUIET_LIMIT = 1000;
  localparam int STREAM_BYTES = 1650;

  typedef logic [8*STORE_BYTES-1:0] hdr_vec_t;

  typedef struct packed {
    status_t          status;
    logic             rec;
    logic [SEQ_W-1:0] seq;
    logic [ID_W-1:0]  id;
  } hdr_result_t;

  typedef enum int {
    HK_VALID,
    HK_BAD_START,
    HK_BAD_END,
    HK_BAD_MAJOR,
    HK_BAD_MINOR,
    HK_RSV_SET,
    HK_MAGIC_AND_VERSION,
    HK_VERSION_AND_RSV,
    HK_GARBAGE
  } hdr_kind_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic [0:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  archive_header_checker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [31:0] start_magic_r = '0;
  logic [31:0] end_magic_r   = '0;
  logic [31:0] major_r       = '0;
  logic [31:0] minor_r       = '0;
  logic        hdr_open      = 1'b0;
  int          hdr_pos       = 0;
  hdr_vec_t    hdr_bytes     = '0;

  hdr_result_t header_results_q[$];
  int          errors          = 0;
  int          bytes_sent      = 0;
  int          quiet_cycles    = 0;
  bit          no_gaps         = 1'b0;
  int          stall_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] nonzero_mask();
    logic [31:0] m;
    m = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : 32'($urandom);
    if (m == '0) m = 32'h1;
    return m;
  endfunction

  function automatic hdr_result_t grade_header(hdr_vec_t h);
    hdr_result_t r;
    r = '0;
    r.status = ST_VALID;
    if (h[8*START_OFS +: 32] != start_magic_r || h[8*END_OFS +: 32] != end_magic_r) begin
      r.status = ST_BAD_MAGIC;
    end else if (h[8*MAJOR_OFS +: 32] != major_r || h[8*MINOR_OFS +: 32] != minor_r) begin
      r.status = ST_BAD_VERSION;
    end else begin
      r.rec = |h[8*REC_OFS +: 8];
      r.seq = h[8*SEQ_OFS +: SEQ_W];
      r.id  = h[8*ID_OFS +: ID_W];
      if (|h[8*RSV_OFS +: 32]) r.status = ST_RSV_NONZERO;
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic first_flag);
    if (first_flag) begin
      hdr_open = 1'b1;
      hdr_pos  = 0;
    end
    if (!hdr_open) return;
    if (hdr_pos < STORE_BYTES) hdr_bytes[8*hdr_pos +: 8] = b;
    if (hdr_pos >= HEADER_LENGTH - 1) begin
      hdr_open = 1'b0;
      hdr_pos  = 0;
      header_results_q = {header_results_q, grade_header(hdr_bytes)};
    end else begin
      hdr_pos++;
    end
  endtask

  function automatic hdr_vec_t make_header(hdr_kind_t kind);
    hdr_vec_t h;
    for (int k = 0; k < STORE_BYTES; k++) h[8*k +: 8] = 8'($urandom);
    if (kind == HK_GARBAGE) return h;
    h[8*REC_OFS +: 8]   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
    h[8*START_OFS +: 32] = start_magic_r;
    h[8*END_OFS +: 32]   = end_magic_r;
    h[8*MAJOR_OFS +: 32] = major_r;
    h[8*MINOR_OFS +: 32] = minor_r;
    h[8*RSV_OFS +: 32]   = '0;
    case (kind)
      HK_BAD_START: h[8*START_OFS +: 32] ^= nonzero_mask();
      HK_BAD_END:   h[8*END_OFS +: 32]   ^= nonzero_mask();
      HK_BAD_MAJOR: h[8*MAJOR_OFS +: 32] ^= nonzero_mask();
      HK_BAD_MINOR: h[8*MINOR_OFS +: 32] ^= nonzero_mask();
      HK_RSV_SET:   h[8*RSV_OFS +: 32]   = nonzero_mask();
      HK_MAGIC_AND_VERSION: begin
        h[8*END_OFS +: 32]   ^= nonzero_mask();
        h[8*MINOR_OFS +: 32] ^= nonzero_mask();
      end
      HK_VERSION_AND_RSV: begin
        h[8*MAJOR_OFS +: 32] ^= nonzero_mask();
        h[8*RSV_OFS +: 32]   = nonzero_mask();
      end
      default: ;
    endcase
    return h;
  endfunction

  function automatic hdr_kind_t random_kind();
    if ($urandom_range(0, 99) < 45) return HK_VALID;
    return hdr_kind_t'($urandom_range(int'(HK_BAD_START), int'(HK_GARBAGE)));
  endfunction

  // one input beat, with a random bubble ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first_flag);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(b, first_flag);
    bytes_sent++;
  endtask

  task automatic send_header(input hdr_vec_t h, input int nbytes);
    for (int k = 0; k < nbytes; k++)
      send_byte(k < STORE_BYTES ? h[8*k +: 8] : 8'($urandom), k == 0);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic stop_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // drain all pending results, then cover the output pipeline
  task automatic wait_idle();
    stop_input();
    while (header_results_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t r, input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_START_MAGIC: start_magic_r = v;
      REG_END_MAGIC:   end_magic_r   = v;
      REG_MAJOR:       major_r       = v;
      REG_MINOR:       minor_r       = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] s, e, mj, mn);
    wait_idle();
    set_reg(REG_START_MAGIC, s);
    set_reg(REG_END_MAGIC, e);
    set_reg(REG_MAJOR, mj);
    set_reg(REG_MINOR, mn);
  endtask

  // reset config is all zero: stray bytes ignored, zero header passes
  task automatic test_idle_bytes();
    hdr_vec_t h;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_noise(3);
    h = '0;
    send_header(h, HEADER_LENGTH);
    send_noise(2);
  endtask

  task automatic test_field_extremes();
    hdr_vec_t h;
    set_regs('1, '1, '1, '1);
    h = make_header(HK_VALID);
    h[8*SEQ_OFS +: SEQ_W] = '1;
    h[8*ID_OFS +: ID_W]   = '1;
    h[8*REC_OFS +: 8]     = 8'hFF;
    h[8*(REC_OFS+1) +: 8] = 8'hFF;
    send_header(h, HEADER_LENGTH);
    set_regs(32'h0000_0001, 32'h8000_0000, 32'h0000_00FF, 32'hFF00_0000);
    h = make_header(HK_VALID);
    h[8*SEQ_OFS +: SEQ_W] = '0;
    h[8*ID_OFS +: ID_W]   = '0;
    h[8*REC_OFS +: 8]     = 8'h01;
    h[8*(REC_OFS+1) +: 8] = 8'h00;
    send_header(h, HEADER_LENGTH);
    // status 3 still carries the extracted fields
    h = make_header(HK_VALID);
    h[8*RSV_OFS +: 32]    = '1;
    h[8*SEQ_OFS +: SEQ_W] = '1;
    h[8*ID_OFS +: ID_W]   = '1;
    h[8*REC_OFS +: 8]     = 8'h80;
    send_header(h, HEADER_LENGTH);
  endtask

  task automatic test_status_kinds();
    set_regs($urandom, $urandom, $urandom, $urandom);
    for (int k = int'(HK_VALID); k <= int'(HK_GARBAGE); k++)
      send_header(make_header(hdr_kind_t'(k)), HEADER_LENGTH);
  endtask

  // first flag inside a header drops the partial one
  task automatic test_restart();
    set_regs($urandom, $urandom, $urandom, $urandom);
    send_byte(8'($urandom), 1'b1);
    send_header(make_header(HK_VALID), HEADER_LENGTH);
    send_header(make_header(HK_BAD_MAJOR), $urandom_range(2, HEADER_LENGTH - 2));
    send_header(make_header(HK_VALID), HEADER_LENGTH);
    no_gaps = 1'b1;
    send_header(make_header(HK_VALID), HEADER_LENGTH - 1);
    send_header(make_header(HK_RSV_SET), HEADER_LENGTH);
    send_header(make_header(HK_VALID), HEADER_LENGTH);
    send_noise(4);
    send_header(make_header(HK_BAD_START), HEADER_LENGTH);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_stream();
    int phase, act;
    logic [31:0] w[4];
    phase = 0;
    while (bytes_sent < STREAM_BYTES) begin
      for (int k = 0; k < 4; k++) begin
        case (phase % 4)
          0: w[k] = '1;
          1: w[k] = '0;
          2: w[k] = $urandom;
          default: w[k] = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
        endcase
      end
      set_regs(w[0], w[1], w[2], w[3]);
      no_gaps = (phase % 3 == 2);
      for (int n = 0; n < 12 && bytes_sent < STREAM_BYTES; n++) begin
        act = $urandom_range(0, 99);
        if (act >= 15 && act < 25) begin
          send_noise($urandom_range(1, 6));
        end else begin
          if (act < 15)
            send_header(make_header(random_kind()), $urandom_range(1, HEADER_LENGTH - 1));
          send_header(make_header(random_kind()), HEADER_LENGTH);
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // result side backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic note_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    hdr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (header_results_q.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, m_tdata);
        errors++;
      end else begin
        want = header_results_q.pop_front();
        note_field("status", 64'(want.status), 64'(m_tdata[STATUS_W-1:0]));
        note_field("recovery_enabled", 64'(want.rec), 64'(m_tdata[STATUS_W]));
        note_field("sequence_res", 64'(want.seq), 64'(m_tdata[STATUS_W+1 +: SEQ_W]));
        note_field("archive_id", want.id, m_tdata[STATUS_W+1+SEQ_W +: ID_W]);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("archive_header_checker_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_START_MAGIC;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_field_extremes();
    test_status_kinds();
    test_restart();
    test_random_stream();

    if (header_results_q.size() != 0) wait_idle();
    else stop_input();
    repeat (20) @(posedge clk);
    if (header_results_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, header_results_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("archive_header_checker_tb OK");
    end else begin
      $display("archive_header_checker_tb NOT OK");
    end
    $finish;
  end

endmodule
